>>> hw/rtl/olss_pkg.sv
// ----------------------------------------------------------------------------
// olss_pkg
// Shared types and codes for the ordered list shift store.
// ----------------------------------------------------------------------------
package olss_pkg;

  localparam int CMD_BITS = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_UPDATE = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_POS   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_SCAN
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic scan_hit;
    logic scan_miss;
  } dp_cmd_t;

  typedef struct packed {
    logic is_find;
    logic empty;
    logic match;
    logic scan_last;
  } dp_stat_t;

endpackage

>>> hw/rtl/olss_cmd_if.sv
// ----------------------------------------------------------------------------
// olss_cmd_if
// Command channel of the ordered list shift store.
// ----------------------------------------------------------------------------
interface olss_cmd_if import olss_pkg::*; #(
  parameter int POS_BITS     = 5,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  logic [CMD_BITS-1:0]     cmd;
  logic [POS_BITS-1:0]     position;
  logic                    append;
  logic [KEY_BITS-1:0]     key_in;
  logic [PAYLOAD_BITS-1:0] payload_in;

  modport source (output valid, cmd, position, append, key_in, payload_in, input ready);
  modport sink   (input valid, cmd, position, append, key_in, payload_in, output ready);
endinterface

>>> hw/rtl/olss_rsp_if.sv
// ----------------------------------------------------------------------------
// olss_rsp_if
// Result channel of the ordered list shift store.
// ----------------------------------------------------------------------------
interface olss_rsp_if import olss_pkg::*; #(
  parameter int POS_BITS     = 5,
  parameter int COUNT_BITS   = 6,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [KEY_BITS-1:0]     key_out;
  logic [PAYLOAD_BITS-1:0] payload_out;
  logic [POS_BITS-1:0]     found_position;
  logic [COUNT_BITS-1:0]   entry_count;

  modport source (output valid, status, key_out, payload_out, found_position, entry_count,
                  input ready);
  modport sink   (input valid, status, key_out, payload_out, found_position, entry_count,
                  output ready);
endinterface

>>> hw/rtl/olss_ctrl.sv
// ----------------------------------------------------------------------------
// olss_ctrl
// Controller: sequences each command through execute or key scan and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module olss_ctrl import olss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  ctl,
  input  dp_stat_t stat
);

  ctl_state_t state;
  ctl_state_t state_next;
  logic       slot_free;
  logic       load;

  assign slot_free = !out_valid || out_ready;
  assign load      = ctl.exec || ctl.scan_hit || ctl.scan_miss;

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: begin
        if (in_valid) state_next = CTL_EXEC;
      end
      CTL_EXEC: begin
        if (stat.is_find && !stat.empty) state_next = CTL_SCAN;
        else if (slot_free) state_next = CTL_IDLE;
      end
      CTL_SCAN: begin
        if ((stat.match || stat.scan_last) && slot_free) state_next = CTL_IDLE;
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      CTL_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      CTL_EXEC: begin
        if (stat.is_find && !stat.empty) ctl.scan_start = 1'b1;
        else ctl.exec = slot_free;
      end
      CTL_SCAN: begin
        if (stat.match) ctl.scan_hit = slot_free;
        else if (stat.scan_last) ctl.scan_miss = slot_free;
        else ctl.scan_step = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_load_slot: assert property (@(posedge clk) disable iff (rst)
    load |-> slot_free) else $error("result loaded over a pending transfer");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == CTL_EXEC) else $error("accept did not start execute");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) != CTL_IDLE) else $error("result raised from idle");

endmodule

>>> hw/rtl/olss_datapath.sv
// ----------------------------------------------------------------------------
// olss_datapath
// Entry cells that shift up or down together, a single read port used by
// get and by the key scan, the entry count and the result registers.
// ----------------------------------------------------------------------------
module olss_datapath import olss_pkg::*; #(
  parameter int DEPTH        = 32,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 64,
  parameter int POS_BITS     = $clog2(DEPTH),
  parameter int COUNT_BITS   = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 ctl,
  output dp_stat_t                stat,
  input  logic [CMD_BITS-1:0]     cmd,
  input  logic [POS_BITS-1:0]     position,
  input  logic                    append,
  input  logic [KEY_BITS-1:0]     key_in,
  input  logic [PAYLOAD_BITS-1:0] payload_in,
  output status_t                 status,
  output logic [KEY_BITS-1:0]     key_out,
  output logic [PAYLOAD_BITS-1:0] payload_out,
  output logic [POS_BITS-1:0]     found_position,
  output logic [COUNT_BITS-1:0]   entry_count
);

  cmd_t                    cmd_r;
  logic [POS_BITS-1:0]     pos_r;
  logic                    app_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;

  logic [KEY_BITS-1:0]     keys [DEPTH];
  logic [PAYLOAD_BITS-1:0] pays [DEPTH];
  logic [KEY_BITS-1:0]     keys_next [DEPTH];
  logic [PAYLOAD_BITS-1:0] pays_next [DEPTH];

  logic [COUNT_BITS-1:0]   count;
  logic [COUNT_BITS-1:0]   count_next;
  logic [POS_BITS-1:0]     idx;

  logic [COUNT_BITS-1:0]   pos_ext;
  logic [COUNT_BITS-1:0]   ins_at;
  logic                    full;
  logic                    ins_bad;
  logic                    pos_bad;
  logic                    insert_do;
  logic                    delete_do;
  logic                    update_do;
  logic [POS_BITS-1:0]     rd_addr;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  status_t                 res_status;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_pay;
  logic [POS_BITS-1:0]     res_pos;

  assign pos_ext = COUNT_BITS'(pos_r);
  assign full    = count == COUNT_BITS'(DEPTH);
  assign ins_at  = app_r ? count : pos_ext;
  assign ins_bad = ins_at > count;
  assign pos_bad = pos_ext >= count;

  assign insert_do = ctl.exec && cmd_r == CMD_INSERT && !full && !ins_bad;
  assign delete_do = ctl.exec && cmd_r == CMD_DELETE && !pos_bad;
  assign update_do = ctl.exec && cmd_r == CMD_UPDATE && !pos_bad;

  assign rd_addr = (cmd_r == CMD_FIND) ? idx : pos_r;
  assign rd_key  = keys[rd_addr];
  assign rd_pay  = pays[rd_addr];

  assign stat.is_find   = cmd_r == CMD_FIND;
  assign stat.empty     = count == '0;
  assign stat.match     = rd_key == key_r;
  assign stat.scan_last = COUNT_BITS'(idx) == count - COUNT_BITS'(1);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [COUNT_BITS-1:0] CELL = COUNT_BITS'(i);
    logic [KEY_BITS-1:0]     up_key;
    logic [PAYLOAD_BITS-1:0] up_pay;
    logic [KEY_BITS-1:0]     dn_key;
    logic [PAYLOAD_BITS-1:0] dn_pay;

    if (i > 0) begin : g_up
      assign up_key = keys[i-1];
      assign up_pay = pays[i-1];
    end else begin : g_up_edge
      assign up_key = keys[i];
      assign up_pay = pays[i];
    end

    if (i < DEPTH - 1) begin : g_dn
      assign dn_key = keys[i+1];
      assign dn_pay = pays[i+1];
    end else begin : g_dn_edge
      assign dn_key = keys[i];
      assign dn_pay = pays[i];
    end

    always_comb begin
      keys_next[i] = keys[i];
      pays_next[i] = pays[i];
      if (insert_do) begin
        if (CELL == ins_at) begin
          keys_next[i] = key_r;
          pays_next[i] = pay_r;
        end else if (CELL > ins_at) begin
          keys_next[i] = up_key;
          pays_next[i] = up_pay;
        end
      end else if (delete_do && CELL >= pos_ext) begin
        keys_next[i] = dn_key;
        pays_next[i] = dn_pay;
      end else if (update_do && CELL == pos_ext) begin
        keys_next[i] = key_r;
        pays_next[i] = pay_r;
      end
    end

    always_ff @(posedge clk) begin
      keys[i] <= keys_next[i];
      pays[i] <= pays_next[i];
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.exec && cmd_r == CMD_CLEAR) count_next = '0;
    else if (insert_do) count_next = count + COUNT_BITS'(1);
    else if (delete_do) count_next = count - COUNT_BITS'(1);
  end

  always_comb begin
    res_status = STAT_OK;
    res_key    = '0;
    res_pay    = '0;
    res_pos    = '0;
    if (ctl.scan_hit) begin
      res_key = rd_key;
      res_pay = rd_pay;
      res_pos = idx;
    end else if (ctl.scan_miss) begin
      res_status = STAT_NOT_FOUND;
    end else begin
      case (cmd_r)
        CMD_INSERT: begin
          if (full) res_status = STAT_FULL;
          else if (ins_bad) res_status = STAT_BAD_POS;
        end
        CMD_DELETE, CMD_UPDATE: begin
          if (pos_bad) res_status = STAT_BAD_POS;
        end
        CMD_GET: begin
          if (pos_bad) begin
            res_status = STAT_BAD_POS;
          end else begin
            res_key = rd_key;
            res_pay = rd_pay;
          end
        end
        CMD_FIND: res_status = STAT_NOT_FOUND;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= cmd_t'(cmd);
      pos_r <= position;
      app_r <= append;
      key_r <= key_in;
      pay_r <= payload_in;
    end
    if (ctl.scan_start) idx <= '0;
    else if (ctl.scan_step) idx <= idx + POS_BITS'(1);
    if (ctl.exec || ctl.scan_hit || ctl.scan_miss) begin
      status         <= res_status;
      key_out        <= res_key;
      payload_out    <= res_pay;
      found_position <= res_pos;
      entry_count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(DEPTH)) else $error("entry count beyond depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_start |-> count != '0) else $error("scan started on an empty list");

  a_read_stable: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && (cmd_r == CMD_GET || cmd_r == CMD_FIND)) |=> $stable(count))
    else $error("read command changed the entry count");

endmodule

>>> hw/rtl/ordered_list_shift_store.sv
// ----------------------------------------------------------------------------
// ordered_list_shift_store
// Bounded ordered list of key and payload entries with insert, delete, get,
// update, find and clear commands, one result per command.
// ----------------------------------------------------------------------------
//   channel   direction   modport   contents
//   req       in          sink      cmd, position, append, key_in, payload_in
//   rsp       out         source    status, key_out, payload_out,
//                                   found_position, entry_count
//
// A command is taken in idle and captured, and the execute state then loads its
// result into the output register; no new command is taken until that is done.
// Find scans the entries one per cycle through the single read port, stopping at
// the first match and examining at most as many entries as the entry count.
// A new command is accepted while the previous result waits on rsp.ready;
// a result that is ready is held until the output register is free.
// Reset empties the list at once; entry contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_shift_store import olss_pkg::*; #(
  parameter int DEPTH        = 32,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input logic        clk,
  input logic        rst,
  olss_cmd_if.sink   req,
  olss_rsp_if.source rsp
);

  localparam int POS_BITS   = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  olss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  olss_datapath #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .POS_BITS     (POS_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .cmd            (req.cmd),
    .position       (req.position),
    .append         (req.append),
    .key_in         (req.key_in),
    .payload_in     (req.payload_in),
    .status         (rsp.status),
    .key_out        (rsp.key_out),
    .payload_out    (rsp.payload_out),
    .found_position (rsp.found_position),
    .entry_count    (rsp.entry_count)
  );

endmodule
